// ===== rtl/core/ssgp_pkg.sv =====
// Shared types, register indexes and step functions for the spatial gain/pan pipeline.
// No dependencies.
`timescale 1ns / 1ps

package ssgp_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_LISTENER_X = 3'd0;
  localparam logic [2:0] CFG_LISTENER_Y = 3'd1;
  localparam logic [2:0] CFG_LISTENER_Z = 3'd2;
  localparam logic [2:0] CFG_FRONT_VEC  = 3'd3;
  localparam logic [2:0] CFG_RIGHT_VEC  = 3'd4;

  localparam int SQRT_STAGES = 16;  // two root bits per stage
  localparam int DIV_STAGES  = 9;   // two quotient bits per stage
  localparam int QBITS       = 18;

  localparam logic [15:0] GAIN_UNITY = 16'd32768;
  localparam logic [19:0] FAC_BIAS   = 20'd262144;  // 0.8 * 10 in Q1.15
  localparam logic [19:0] RECIP_TEN  = 20'd838861;  // ceil(2^23 / 10)

  typedef struct packed {
    logic        pos;
    logic        far;
    logic [30:0] radius;
    logic [7:0]  tag;
  } meta_t;

  typedef struct packed {
    logic        v;
    meta_t       m;
    logic [63:0] n;
    logic [63:0] res;
    logic [51:0] sf;
    logic [51:0] sr;
  } sqst_t;

  typedef struct packed {
    logic [52:0] n;
    logic [52:0] dd;
    logic [17:0] q;
  } dv_t;

  typedef struct packed {
    logic  v;
    meta_t m;
    dv_t   l;
    dv_t   f;
    logic  fneg;
    logic  fsat;
    dv_t   r;
    logic  rneg;
    logic  rsat;
  } dvst_t;

  // one digit of the bitwise integer square root
  function automatic sqst_t sqrt_step(sqst_t s, logic [63:0] bit_v);
    sqst_t       o;
    logic [63:0] t;
    o = s;
    t = s.res + bit_v;
    if (s.n >= t) begin
      o.n   = s.n - t;
      o.res = (s.res >> 1) + bit_v;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // one bit of restoring division
  function automatic dv_t div_step(dv_t s);
    dv_t o;
    o = s;
    if (s.n >= s.dd) begin
      o.n = s.n - s.dd;
      o.q = {s.q[QBITS-2:0], 1'b1};
    end else begin
      o.q = {s.q[QBITS-2:0], 1'b0};
    end
    o.dd = s.dd >> 1;
    return o;
  endfunction

endpackage

// ===== rtl/core/spatial_source_gain_pan_top.sv =====
// Top level of the spatial source gain/pan pipeline.
// Depends on ssgp_pkg.
`timescale 1ns / 1ps

// Per-source gain, left/right balance and in-range flag from the source position
// and radius against the listener position and front/right unit vectors held in
// registers. Fully pipelined: one source beat may enter every cycle while in_stall_o
// is low, and its result passes through 3 front-end stages for offsets, squares and
// dot products and sums, 16 square-root stages, 10 division stages, 2 gain stages and
// the output register. The whole pipeline advances together; it holds while a
// result sits in the output register with out_stall_i high, and in_stall_o
// reports that. Registers are written through the cfg port, always ready, and
// must only be changed while no beat is in flight.
module spatial_source_gain_pan_top
  import ssgp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i,
  // source beats
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] source_x_i,
  input  logic signed [31:0] source_y_i,
  input  logic signed [31:0] source_z_i,
  input  logic [30:0]        audible_radius_i,
  input  logic               positioned_i,
  input  logic [7:0]         source_tag_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               in_range_o,
  output logic [15:0]        gain_o,
  output logic signed [15:0] balance_o,
  output logic [7:0]         result_tag_o
);

  // ---------------- configuration registers ----------------
  logic [31:0] lis_x_q, lis_y_q, lis_z_q;
  logic [47:0] front_q, right_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lis_x_q <= '0;
      lis_y_q <= '0;
      lis_z_q <= '0;
      front_q <= '0;
      right_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LISTENER_X: lis_x_q <= cfg_data_i[31:0];
        CFG_LISTENER_Y: lis_y_q <= cfg_data_i[31:0];
        CFG_LISTENER_Z: lis_z_q <= cfg_data_i[31:0];
        CFG_FRONT_VEC:  front_q <= cfg_data_i;
        CFG_RIGHT_VEC:  right_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline enable ----------------
  typedef struct packed {
    logic               v;
    logic               in_range;
    logic [15:0]        gain;
    logic signed [15:0] bal;
    logic [7:0]         tag;
  } out_t;

  out_t out_q, out_d;
  logic en;

  // everything moves unless a finished result is being held off
  assign en         = !out_q.v || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------- stage 0: offsets and coarse range check ----------------
  typedef struct packed {
    logic               v;
    meta_t              m;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [30:0]        ax;
    logic [30:0]        ay;
    logic [30:0]        az;
  } s0_t;

  s0_t s0_q, s0_d;
  logic signed [32:0] dx0, dy0, dz0;
  logic [32:0] ax0, ay0, az0;

  always_comb begin
    dx0 = $signed({source_x_i[31], source_x_i}) - $signed({lis_x_q[31], lis_x_q});
    dy0 = $signed({source_y_i[31], source_y_i}) - $signed({lis_y_q[31], lis_y_q});
    dz0 = $signed({source_z_i[31], source_z_i}) - $signed({lis_z_q[31], lis_z_q});
    ax0 = dx0[32] ? 33'(-dx0) : 33'(dx0);
    ay0 = dy0[32] ? 33'(-dy0) : 33'(dy0);
    az0 = dz0[32] ? 33'(-dz0) : 33'(dz0);
    s0_d.v        = in_valid_i;
    s0_d.m.pos    = positioned_i;
    // any single axis beyond the radius already puts the source out of range
    s0_d.m.far    = (ax0 > {2'b00, audible_radius_i}) || (ay0 > {2'b00, audible_radius_i})
                  || (az0 > {2'b00, audible_radius_i});
    s0_d.m.radius = audible_radius_i;
    s0_d.m.tag    = source_tag_i;
    s0_d.dx       = dx0;
    s0_d.dy       = dy0;
    s0_d.dz       = dz0;
    s0_d.ax       = ax0[30:0];
    s0_d.ay       = ay0[30:0];
    s0_d.az       = az0[30:0];
  end

  // ---------------- stage 1: squares and dot-product terms ----------------
  typedef struct packed {
    logic               v;
    meta_t              m;
    logic [61:0]        sqx;
    logic [61:0]        sqy;
    logic [61:0]        sqz;
    logic [61:0]        r2;
    logic signed [48:0] pfx;
    logic signed [48:0] pfy;
    logic signed [48:0] pfz;
    logic signed [48:0] prx;
    logic signed [48:0] pry;
    logic signed [48:0] prz;
  } s1_t;

  s1_t s1_q, s1_d;

  always_comb begin
    s1_d.v   = s0_q.v;
    s1_d.m   = s0_q.m;
    s1_d.sqx = 62'(s0_q.ax) * 62'(s0_q.ax);
    s1_d.sqy = 62'(s0_q.ay) * 62'(s0_q.ay);
    s1_d.sqz = 62'(s0_q.az) * 62'(s0_q.az);
    s1_d.r2  = 62'(s0_q.m.radius) * 62'(s0_q.m.radius);
    s1_d.pfx = $signed(front_q[15:0])  * s0_q.dx;
    s1_d.pfy = $signed(front_q[31:16]) * s0_q.dy;
    s1_d.pfz = $signed(front_q[47:32]) * s0_q.dz;
    s1_d.prx = $signed(right_q[15:0])  * s0_q.dx;
    s1_d.pry = $signed(right_q[31:16]) * s0_q.dy;
    s1_d.prz = $signed(right_q[47:32]) * s0_q.dz;
  end

  // ---------------- stage 2: sums, exact range check ----------------
  sqst_t sq_q [SQRT_STAGES+1];
  sqst_t sq0_d;
  logic [63:0] d2;
  logic signed [51:0] sumf, sumr;

  always_comb begin
    d2   = 64'(s1_q.sqx) + 64'(s1_q.sqy) + 64'(s1_q.sqz);
    sumf = 52'(s1_q.pfx) + 52'(s1_q.pfy) + 52'(s1_q.pfz);
    sumr = 52'(s1_q.prx) + 52'(s1_q.pry) + 52'(s1_q.prz);
    sq0_d.v     = s1_q.v;
    sq0_d.m     = s1_q.m;
    sq0_d.m.far = s1_q.m.far || (d2 > 64'(s1_q.r2));
    sq0_d.n     = d2;
    sq0_d.res   = '0;
    sq0_d.sf    = sumf <<< 1;
    sq0_d.sr    = sumr <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q     <= '0;
      s1_q     <= '0;
      sq_q[0]  <= '0;
    end else if (en) begin
      s0_q     <= s0_d;
      s1_q     <= s1_d;
      sq_q[0]  <= sq0_d;
    end
  end

  // ---------------- square root: two digits per stage ----------------
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    sqst_t mid, nxt;
    always_comb begin
      mid = sqrt_step(sq_q[k], 64'(1) << (62 - 4*k));
      nxt = sqrt_step(mid,     64'(1) << (60 - 4*k));
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[k+1] <= '0;
      end else if (en) begin
        sq_q[k+1] <= nxt;
      end
    end
  end

  // ---------------- division setup ----------------
  dvst_t dv_q [DIV_STAGES+1];
  dvst_t dv0_d;
  logic [31:0] root_w, dsafe, rmd;
  logic [51:0] magf, magr;
  logic        dz_w;

  always_comb begin
    root_w = sq_q[SQRT_STAGES].res[31:0];
    dz_w   = (root_w == '0);
    dsafe  = dz_w ? 32'd1 : root_w;
    magf  = sq_q[SQRT_STAGES].sf[51] ? 52'(-$signed(sq_q[SQRT_STAGES].sf))
                                     : sq_q[SQRT_STAGES].sf;
    magr  = sq_q[SQRT_STAGES].sr[51] ? 52'(-$signed(sq_q[SQRT_STAGES].sr))
                                     : sq_q[SQRT_STAGES].sr;
    rmd   = {1'b0, sq_q[SQRT_STAGES].m.radius} - root_w;
    dv0_d.v    = sq_q[SQRT_STAGES].v;
    dv0_d.m    = sq_q[SQRT_STAGES].m;
    // linear fall-off; a coincident source lands on exactly unity, zero radius too
    dv0_d.l.n  = dz_w ? (53'd1 << 15) : (53'(rmd) << 15);
    dv0_d.l.dd = dz_w ? (53'd1 << (QBITS - 1))
                      : (53'(sq_q[SQRT_STAGES].m.radius) << (QBITS - 1));
    dv0_d.l.q  = '0;
    // dots are zero for a coincident source
    dv0_d.f.n  = dz_w ? 53'd0 : 53'(magf);
    dv0_d.f.dd = 53'(dsafe) << (QBITS - 1);
    dv0_d.f.q  = '0;
    dv0_d.fneg = sq_q[SQRT_STAGES].sf[51];
    dv0_d.fsat = !dz_w && (53'(magf) >= (53'(dsafe) << QBITS));
    dv0_d.r.n  = dz_w ? 53'd0 : 53'(magr);
    dv0_d.r.dd = 53'(dsafe) << (QBITS - 1);
    dv0_d.r.q  = '0;
    dv0_d.rneg = sq_q[SQRT_STAGES].sr[51];
    dv0_d.rsat = !dz_w && (53'(magr) >= (53'(dsafe) << QBITS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= '0;
    end else if (en) begin
      dv_q[0] <= dv0_d;
    end
  end

  // ---------------- three dividers, two quotient bits per stage ----------------
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    dvst_t nxt;
    always_comb begin
      nxt   = dv_q[k];
      nxt.l = div_step(div_step(dv_q[k].l));
      nxt.f = div_step(div_step(dv_q[k].f));
      nxt.r = div_step(div_step(dv_q[k].r));
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= '0;
      end else if (en) begin
        dv_q[k+1] <= nxt;
      end
    end
  end

  // ---------------- post 1: clamps, front factor times 1/10 ----------------
  typedef struct packed {
    logic               v;
    meta_t              m;
    logic [15:0]        lin;
    logic signed [15:0] bal;
    logic [39:0]        xm;
  } p1_t;

  p1_t p1_q, p1_d;
  logic [17:0] fq, rq, fmag;
  logic [19:0] xf;

  always_comb begin
    fq = dv_q[DIV_STAGES].f.q;
    rq = dv_q[DIV_STAGES].r.q;
    // front dot clamped to [-4.0, 4.0)
    if (dv_q[DIV_STAGES].fneg) begin
      fmag = (dv_q[DIV_STAGES].fsat || fq > 18'd131072) ? 18'd131072 : fq;
      xf   = FAC_BIAS - {1'b0, fmag, 1'b0};
    end else begin
      fmag = (dv_q[DIV_STAGES].fsat || fq > 18'd131071) ? 18'd131071 : fq;
      xf   = FAC_BIAS + {1'b0, fmag, 1'b0};
    end
    p1_d.v   = dv_q[DIV_STAGES].v;
    p1_d.m   = dv_q[DIV_STAGES].m;
    p1_d.lin = dv_q[DIV_STAGES].l.q[15:0];
    if (dv_q[DIV_STAGES].rneg) begin
      p1_d.bal = (dv_q[DIV_STAGES].rsat || rq > 18'd32768) ? -16'sd32768
                                                           : 16'(-$signed({1'b0, rq}));
    end else begin
      p1_d.bal = (dv_q[DIV_STAGES].rsat || rq > 18'd32767) ? 16'sd32767 : $signed(rq[15:0]);
    end
    p1_d.xm = 40'(xf) * 40'(RECIP_TEN);
  end

  // ---------------- post 2: gain product ----------------
  typedef struct packed {
    logic               v;
    meta_t              m;
    logic signed [15:0] bal;
    logic [31:0]        prod;
  } p2_t;

  p2_t p2_q, p2_d;
  logic [16:0] fac_raw;
  logic [15:0] fac;

  always_comb begin
    fac_raw   = p1_q.xm[39:23];
    fac       = (fac_raw > 17'(GAIN_UNITY)) ? GAIN_UNITY : fac_raw[15:0];
    p2_d.v    = p1_q.v;
    p2_d.m    = p1_q.m;
    p2_d.bal  = p1_q.bal;
    p2_d.prod = 32'(p1_q.lin) * 32'(fac);
  end

  // ---------------- output register ----------------
  always_comb begin
    out_d.v   = p2_q.v;
    out_d.tag = p2_q.m.tag;
    if (!p2_q.m.pos) begin
      out_d.in_range = 1'b1;
      out_d.gain     = GAIN_UNITY;
      out_d.bal      = '0;
    end else if (p2_q.m.far) begin
      out_d.in_range = 1'b0;
      out_d.gain     = '0;
      out_d.bal      = '0;
    end else begin
      out_d.in_range = 1'b1;
      out_d.gain     = p2_q.prod[30:15];
      out_d.bal      = p2_q.bal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q  <= '0;
      p2_q  <= '0;
      out_q <= '0;
    end else if (en) begin
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o  = out_q.v;
  assign in_range_o   = out_q.in_range;
  assign gain_o       = out_q.gain;
  assign balance_o    = out_q.bal;
  assign result_tag_o = out_q.tag;

`ifndef SYNTH
  // a held result must freeze the input side
  a_hold_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while result held");

  // out-of-range results carry no gain or pan
  a_far_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> gain_o == '0 && balance_o == '0)
    else $error("out-of-range result not silent");

  // gain never exceeds unity
  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gain_o <= GAIN_UNITY)
    else $error("gain above unity");
`endif

endmodule

// ===== dv/spatial_source_gain_pan_top_test.sv =====
// Self-checking testbench for spatial_source_gain_pan_top: directed and random source beats
// against an in-bench gain/pan predictor. Depends on ssgp_pkg and the RTL top.
`timescale 1ns / 1ps

module spatial_source_gain_pan_top_test;
  import ssgp_pkg::*;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
    logic [30:0] radius;
    logic        pos;
    logic [7:0]  tag;
  } src_beat_t;

  typedef struct packed {
    logic        in_range;
    logic [15:0] gain;
    logic [15:0] balance;
    logic [7:0]  tag;
  } gain_pan_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // config channel, driven only by the main sequence
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = CFG_LISTENER_X;
  logic [47:0] cfg_data = '0;
  logic        cfg_ready;

  // source channel
  src_beat_t src_cur = '0;
  logic      src_valid = 1'b0;
  logic      src_stall;

  // result channel
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        res_in_range;
  logic [15:0] res_gain;
  logic [15:0] res_balance;
  logic [7:0]  res_tag;

  // bench copy of the listener registers
  logic [31:0] lis_x = '0, lis_y = '0, lis_z = '0;
  logic [47:0] front_vec = '0, right_vec = '0;

  src_beat_t pending_beats[$];
  gain_pan_t expected_gp[$];

  int  err_count = 0;
  int  beats_sent = 0;
  int  results_seen = 0;
  int  far_seen = 0;
  int  cfg_writes = 0;
  bit  quiet = 1'b0;      // no idling on either side
  bit  hold_req = 1'b0;   // one long receiver hold-off
  int  hold_cnt = 0;
  int  src_gap = 0;
  int  res_gap = 0;

  localparam int HOLD_CYCLES = 300;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  spatial_source_gain_pan_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (src_valid),
    .in_stall_o       (src_stall),
    .source_x_i       (src_cur.sx),
    .source_y_i       (src_cur.sy),
    .source_z_i       (src_cur.sz),
    .audible_radius_i (src_cur.radius),
    .positioned_i     (src_cur.pos),
    .source_tag_i     (src_cur.tag),
    .out_valid_o      (res_valid),
    .out_stall_i      (res_stall),
    .in_range_o       (res_in_range),
    .gain_o           (res_gain),
    .balance_o        (res_balance),
    .result_tag_o     (res_tag)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // floor(sqrt(n)), one root bit at a time from the top
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root, cand;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  // Q1.15 dot of a packed Q1.14 vector with the offset scaled by 1/dlen
  function automatic longint unit_dot(logic [47:0] vec, longint dx, longint dy,
                                      longint dz, longint unsigned dlen);
    longint acc;
    if (dlen == 0) return 0;
    acc = longint'($signed(vec[15:0])) * dx + longint'($signed(vec[31:16])) * dy
        + longint'($signed(vec[47:32])) * dz;
    return (2 * acc) / longint'(dlen);
  endfunction

  function automatic gain_pan_t predict_gain_pan(src_beat_t b);
    gain_pan_t       o;
    longint          dx, dy, dz, ax, ay, az, fdot, rdot, fac;
    longint unsigned rad, d2, dlen, lin;
    bit              far;
    o.in_range = 1'b1;
    o.gain     = GAIN_UNITY;
    o.balance  = '0;
    o.tag      = b.tag;
    if (!b.pos) return o;
    rad = b.radius;
    dx = longint'($signed(b.sx)) - longint'($signed(lis_x));
    dy = longint'($signed(b.sy)) - longint'($signed(lis_y));
    dz = longint'($signed(b.sz)) - longint'($signed(lis_z));
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    // a single axis beyond the radius settles it before squaring
    far = ax > longint'(rad) || ay > longint'(rad) || az > longint'(rad);
    if (!far) begin
      d2 = ax * ax + ay * ay + az * az;
      far = d2 > rad * rad;
    end
    if (far) begin
      o.in_range = 1'b0;
      o.gain     = '0;
      return o;
    end
    dlen = floor_root(d2);
    lin  = (dlen == 0) ? 64'd32768 : ((rad - dlen) << 15) / rad;
    fdot = unit_dot(front_vec, dx, dy, dz, dlen);
    if (fdot < -131072) fdot = -131072;
    if (fdot > 131071) fdot = 131071;
    fac = (2 * fdot + 262144) / 10;
    if (fac > 32768) fac = 32768;
    o.gain = 16'((lin * longint'(fac)) >> 15);
    rdot = unit_dot(right_vec, dx, dy, dz, dlen);
    if (rdot < -32768) rdot = -32768;
    if (rdot > 32767) rdot = 32767;
    o.balance = 16'(rdot);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Source driver: pops pending beats, random idle bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid <= 1'b0;
      src_cur   <= '0;
      src_gap   <= 0;
    end else begin : drive
      bit fire;
      fire = src_valid && !src_stall;
      if (fire) begin
        expected_gp.insert(expected_gp.size(), predict_gain_pan(src_cur));
        beats_sent++;
      end
      if (!src_valid || fire) begin
        if (src_gap > 0) begin
          src_gap   <= src_gap - 1;
          src_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          src_gap   <= $urandom_range(0, 5);  // random idle burst
          src_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          src_cur   <= pending_beats.pop_front();
          src_valid <= 1'b1;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks against the oldest expectation, random stalls
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [7:0] tag, longint got, longint want);
    $display("MISMATCH %s tag=%0d got=%0d expected=%0d at %0t", what, tag, got, want, $time);
    err_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stall <= 1'b0;
      res_gap   <= 0;
    end else begin : watch
      gain_pan_t want;
      if (res_valid && !res_stall) begin
        results_seen++;
        if (expected_gp.size() == 0) begin
          report_mismatch("unexpected beat", res_tag, res_tag, -1);
        end else begin
          want = expected_gp.pop_front();
          if (!want.in_range) far_seen++;
          if (res_tag !== want.tag)
            report_mismatch("result_tag", want.tag, res_tag, want.tag);
          if (res_in_range !== want.in_range)
            report_mismatch("in_range", want.tag, res_in_range, want.in_range);
          if (res_gain !== want.gain)
            report_mismatch("gain", want.tag, res_gain, want.gain);
          if (res_balance !== want.balance)
            report_mismatch("balance", want.tag, $signed(res_balance), $signed(want.balance));
        end
      end
      if (hold_req && hold_cnt < HOLD_CYCLES) begin
        res_stall <= 1'b1;
      end else if (res_gap > 0) begin
        res_gap   <= res_gap - 1;
        res_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        res_gap   <= $urandom_range(0, 5);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    while (!cfg_ready) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LISTENER_X: lis_x = val[31:0];
      CFG_LISTENER_Y: lis_y = val[31:0];
      CFG_LISTENER_Z: lis_z = val[31:0];
      CFG_FRONT_VEC:  front_vec = val;
      CFG_RIGHT_VEC:  right_vec = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_listener(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [47:0] fv, logic [47:0] rv);
    write_reg(CFG_LISTENER_X, {16'd0, x});
    write_reg(CFG_LISTENER_Y, {16'd0, y});
    write_reg(CFG_LISTENER_Z, {16'd0, z});
    write_reg(CFG_FRONT_VEC, fv);
    write_reg(CFG_RIGHT_VEC, rv);
  endtask

  // every queued beat sent and every result back
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_beats.size() != 0 || src_valid || expected_gp.size() != 0)
      @(negedge clk_i);
  endtask

  function automatic void add_beat(longint x, longint y, longint z, longint r,
                                   bit pos, logic [7:0] tag);
    src_beat_t b;
    b.sx = x[31:0];
    b.sy = y[31:0];
    b.sz = z[31:0];
    b.radius = r[30:0];
    b.pos = pos;
    b.tag = tag;
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // random unit vector in Q1.14
  function automatic logic [47:0] rand_unit();
    real x, y, z, n;
    logic [15:0] c[3];
    do begin
      x = real'($urandom_range(0, 2000)) - 1000.0;
      y = real'($urandom_range(0, 2000)) - 1000.0;
      z = real'($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(x * x + y * y + z * z);
    end while (n < 1.0);
    c[0] = 16'($rtoi(x / n * 16384.0));
    c[1] = 16'($rtoi(y / n * 16384.0));
    c[2] = 16'($rtoi(z / n * 16384.0));
    return {c[2], c[1], c[0]};
  endfunction

  function automatic longint rand_offset(longint span);
    longint v;
    v = longint'($urandom_range(0, 32'(span)));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // mostly sources scattered around the listener, up to 1.25 radii per axis, some noise
  function automatic void add_random_beat();
    longint r, span;
    if ($urandom_range(0, 9) < 8) begin
      r = longint'($urandom_range(1, 32'h7FFF_FFFF)) >> $urandom_range(0, 30);
      if (r == 0) r = 1;
      span = r + r / 4;
      add_beat(longint'($signed(lis_x)) + rand_offset(span),
               longint'($signed(lis_y)) + rand_offset(span),
               longint'($signed(lis_z)) + rand_offset(span),
               r, $urandom_range(0, 15) != 0, 8'($urandom));
    end else begin
      r = longint'($urandom_range(1, 32'h7FFF_FFFF));
      add_beat($urandom, $urandom, $urandom, r, $urandom_range(0, 1), 8'($urandom));
    end
  endfunction

  // half a batch, full drain so the sender sits idle, then the rest
  task automatic random_batch(int n);
    for (int i = 0; i < n / 2; i++) add_random_beat();
    wait_drained();
    for (int i = n / 2; i < n; i++) add_random_beat();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  localparam longint ONE = 65536;   // 1.0 in Q16.16
  localparam longint RMAX = 64'h7FFF_FFFF;

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers at reset: zero vectors, so positioned gain is 0.8 of the fall-off
    add_beat(5 * ONE, 0, 0, 10 * ONE, 1'b0, 8'd0);            // unpositioned
    add_beat(0, 0, 0, 10 * ONE, 1'b1, 8'd1);                  // coincident
    add_beat(0, 0, 0, 1, 1'b1, 8'd2);                         // coincident, tiny radius
    add_beat(3 * ONE, 4 * ONE, 0, 10 * ONE, 1'b1, 8'd3);
    add_beat(-1, 0, 0, 1, 1'b1, 8'd4);                        // distance equals radius
    wait_drained();

    // listener at origin, facing +y, right is +x
    set_listener('0, '0, '0, {16'd0, 16'd16384, 16'd0}, {16'd0, 16'd0, 16'd16384});
    add_beat(0, 5 * ONE, 0, 10 * ONE, 1'b1, 8'd10);           // straight ahead
    add_beat(0, -5 * ONE, 0, 10 * ONE, 1'b1, 8'd11);          // behind
    add_beat(5 * ONE, 0, 0, 10 * ONE, 1'b1, 8'd12);           // hard right
    add_beat(-5 * ONE, 0, 0, 10 * ONE, 1'b1, 8'd13);          // hard left
    add_beat(11 * ONE, 0, 0, 10 * ONE, 1'b1, 8'd14);          // one axis past radius
    add_beat(7 * ONE, 7 * ONE, 7 * ONE, 10 * ONE, 1'b1, 8'd15); // far only by distance
    add_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, RMAX, 1'b1, 8'd16);
    add_beat(32'h8000_0000, 0, 0, RMAX, 1'b1, 8'd17);
    add_beat(0, 0, 32'h7FFF_FFFF, RMAX, 1'b1, 8'd255);
    wait_drained();
    random_batch(200);

    // extreme listener and unnormalised vectors drive both dot clamps
    set_listener(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                 {16'h7FFF, 16'h8000, 16'h8000}, {16'h7FFF, 16'h7FFF, 16'h8000});
    add_beat(32'h7FFF_FFFF, 32'h8000_0000, 0, RMAX, 1'b1, 8'd20); // offsets beyond 32 bits
    add_beat(32'h8000_0000 + 1000, 32'h7FFF_FFFF, 0, 5000, 1'b1, 8'd21);
    add_beat(32'h8000_0000, 32'h7FFF_FFFF - 1000, 0, 5000, 1'b1, 8'd22);
    add_beat(32'h8000_0000, 32'h7FFF_FFFF, 1000, 5000, 1'b1, 8'd23);
    add_beat(32'h8000_0000, 32'h7FFF_FFFF, -1000, 5000, 1'b1, 8'd24);
    wait_drained();
    random_batch(150);

    // receiver holds off long while the sender keeps offering
    set_listener($urandom, $urandom, $urandom, rand_unit(), rand_unit());
    for (int i = 0; i < 150; i++) add_random_beat();
    hold_req = 1'b1;
    wait_drained();
    random_batch(150);

    for (int p = 0; p < 3; p++) begin
      set_listener($urandom >> $urandom_range(0, 31), $urandom, $urandom >> 8,
                   rand_unit(), rand_unit());
      random_batch(150);
    end

    // closing stretch with no idling on either side
    quiet = 1'b1;
    set_listener('0, 32'h0001_0000, 32'hFFFF_0000, rand_unit(), rand_unit());
    random_batch(150);

    repeat (40) @(posedge clk_i);
    $display("Covered %0d source beats over %0d register writes; %0d results, %0d out of range.",
             beats_sent, cfg_writes, results_seen, far_seen);
    if (err_count == 0 && expected_gp.size() == 0) begin
      $display("spatial_source_gain_pan_top verification clean");
    end else begin
      $display("%0d mismatches, %0d results still owed", err_count, expected_gp.size());
      $display("spatial_source_gain_pan_top verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still owed", expected_gp.size());
    $display("spatial_source_gain_pan_top verification failed");
    $finish;
  end

endmodule

// ===== spatial_source_gain_pan_top.f =====
rtl/core/ssgp_pkg.sv
rtl/core/spatial_source_gain_pan_top.sv
dv/spatial_source_gain_pan_top_test.sv
